[hw/rtl/gn3_pkg.sv]
// ============================================================================
// gn3_pkg: shared types and constants for the 3D gradient noise block
// Fixed-point word type, fade codes, operation codes, register indexes and
// the edge-gradient lookup used by the dot-product logic.
// ============================================================================
package gn3_pkg;

    // Q.16 working word, wide enough for every intermediate of a sample
    localparam int QW      = 25;
    localparam int FRAC_W  = 16;
    localparam int COORD_W = 32;
    localparam int VALUE_W = 8;
    localparam int NOISE_W = 18;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q ONE_Q16     = t_q'(65536);
    localparam t_q THREE_Q16   = t_q'(196608);
    localparam t_q TEN_Q16     = t_q'(655360);
    localparam t_q FIFTEEN_Q16 = t_q'(983040);

    // Item operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register index decoded from paddr[2]
    localparam logic REG_FADE_CURVE = 1'b0;

    typedef enum logic [1:0] {
        FADE_LINEAR  = 2'd0,
        FADE_CUBIC   = 2'd1,
        FADE_QUINTIC = 2'd2
    } t_fade;

    // One gradient component: zero, plus one or minus one
    typedef enum logic [1:0] {
        G_ZERO = 2'd0,
        G_POS  = 2'd1,
        G_NEG  = 2'd2
    } t_gdir;

    typedef struct packed {
        t_gdir gx;
        t_gdir gy;
        t_gdir gz;
    } t_grad;

    // Remainder by 12 with five compare-subtract steps
    function automatic logic [3:0] mod12(input logic [7:0] h);
        logic [7:0] r;
        r = h;
        for (int s = 4; s >= 0; s--) begin
            if (r >= (8'd12 << s)) begin
                r = r - (8'd12 << s);
            end
        end
        return r[3:0];
    endfunction

    // Pick one of the twelve cube-edge gradients
    function automatic t_grad grad_of(input logic [7:0] h);
        t_grad g;
        case (mod12(h))
            4'd0:    g = '{G_POS,  G_POS,  G_ZERO};
            4'd1:    g = '{G_NEG,  G_POS,  G_ZERO};
            4'd2:    g = '{G_POS,  G_NEG,  G_ZERO};
            4'd3:    g = '{G_NEG,  G_NEG,  G_ZERO};
            4'd4:    g = '{G_POS,  G_ZERO, G_POS};
            4'd5:    g = '{G_NEG,  G_ZERO, G_POS};
            4'd6:    g = '{G_POS,  G_ZERO, G_NEG};
            4'd7:    g = '{G_NEG,  G_ZERO, G_NEG};
            4'd8:    g = '{G_ZERO, G_POS,  G_POS};
            4'd9:    g = '{G_ZERO, G_NEG,  G_POS};
            4'd10:   g = '{G_ZERO, G_POS,  G_NEG};
            4'd11:   g = '{G_ZERO, G_NEG,  G_NEG};
            default: g = '{G_ZERO, G_ZERO, G_ZERO};
        endcase
        return g;
    endfunction

    // Signed contribution of one component
    function automatic t_q grad_term(input t_gdir d, input t_q v);
        t_q r;
        case (d)
            G_POS:   r = v;
            G_NEG:   r = -v;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/gn3_if.sv]
// ============================================================================
// gn3_if: valid/ready channels of the 3D gradient noise block
// Input channel carries load and sample items, output channel the noise.
// ============================================================================
interface gn3_in_if;
    import gn3_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [VALUE_W-1:0]         table_index;
    logic [VALUE_W-1:0]         table_value;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;

    modport source (
        output valid, operation, table_index, table_value, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, operation, table_index, table_value, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

interface gn3_out_if;
    import gn3_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [NOISE_W-1:0]  noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

[hw/rtl/gradient_noise_3d_top.sv]
// ============================================================================
// gradient_noise_3d_top: 3D gradient noise over signed Q16.16 points
// Sequencer around one shared multiply-round unit and one table read port.
// ============================================================================
// Usage:
//   i_in carries two kinds of beat. A load beat (operation 0) writes one
//   permutation table entry and returns nothing. A sample
//   beat (operation 1) returns one beat on o_out with the noise as signed
//   Q.16, saturated to plus or minus 1.0.
//   Every table entry a sample can touch must be loaded first.
//   A sample runs through fade (linear, cubic or quintic), chained table
//   reads, blending and a hand-off to the output register; the next beat
//   is taken once the sequencer is back in idle. Fade and blend share the
//   single multiplier, the hash reads share the single table read port.
//   i_in.ready is high only while no sample is in flight.
//   If o_out is stalled, the finished result waits in the output register
//   and the block can accept one more beat; a second finished result holds
//   inside the block until the output register is free.
//   Reset clears the sequencer, drops any pending output and sets the fade
//   curve to quintic. The table is not cleared.
//   APB register 0 (address 0): fade_curve, 0 linear, 1 cubic, 2 quintic;
//   a write of 3 stores quintic.
// ============================================================================
module gradient_noise_3d_top #(
    parameter int TABLE_SIZE = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gn3_in_if.sink        i_in,
    gn3_out_if.source     o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import gn3_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int SW = ((IW > VALUE_W) ? IW : VALUE_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FADE,
        ST_HASH,
        ST_LERP,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [3:0]           r_step;
    logic [1:0]           r_axis;
    t_fade                r_fade;
    logic [FRAC_W-1:0]    r_frac [3];
    logic [IW-1:0]        r_cell [3];
    t_q                   r_fw   [3];
    t_q                   r_tmp;
    logic [VALUE_W-1:0]   r_h    [6];
    t_q                   r_d    [8];
    t_q                   r_l    [6];
    logic [NOISE_W-1:0]   r_res;
    logic                 r_ov;
    logic [NOISE_W-1:0]   r_nv;

    logic                 in_acc;
    logic                 out_load;
    logic                 cfg_wr;
    logic [1:0]           cfg_val;
    t_q                   t_cur;
    logic [3:0]           fade_last;
    t_q                   mac_a;
    t_q                   mac_b;
    t_q                   mac_c;
    t_q                   mac_y;
    t_q                   lw;
    t_q                   la;
    t_q                   lb;
    logic                 ram_we;
    logic [IW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;
    logic [2:0]           corner;
    t_grad                grad;
    t_q                   dx;
    t_q                   dy;
    t_q                   dz;
    t_q                   dot;
    logic [NOISE_W-1:0]   n_noise;

    // Table index of hash value plus lattice offset, wrapped to the table
    function automatic logic [IW-1:0] hadd(input logic [VALUE_W-1:0] hv,
                                           input logic [IW-1:0] idx,
                                           input logic inc);
        logic [SW-1:0] s;
        s = SW'(hv) + SW'(idx) + SW'(inc);
        return s[IW-1:0];
    endfunction

    // Handshakes
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.noise_value = r_nv;
    assign out_load    = (r_state == ST_DONE) && (!r_ov || o_out.ready);

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_FADE_CURVE);
    assign cfg_val = (pwdata[1:0] == 2'd3) ? FADE_QUINTIC : pwdata[1:0];
    assign prdata  = (paddr[2] == REG_FADE_CURVE) ? {30'd0, r_fade} : 32'd0;

    // Fraction of the axis being faded
    assign t_cur = t_q'({1'b0, r_frac[r_axis]});

    always_comb begin
        case (r_fade)
            FADE_LINEAR: fade_last = 4'd0;
            FADE_CUBIC:  fade_last = 4'd2;
            default:     fade_last = 4'd4;
        endcase
    end

    // Lerp operand select: weight, low and high end
    always_comb begin
        lw = '0;
        la = '0;
        lb = '0;
        case (r_step)
            4'd0: begin
                lw = r_fw[0]; la = r_d[0]; lb = r_d[1];
            end
            4'd1: begin
                lw = r_fw[0]; la = r_d[2]; lb = r_d[3];
            end
            4'd2: begin
                lw = r_fw[0]; la = r_d[4]; lb = r_d[5];
            end
            4'd3: begin
                lw = r_fw[0]; la = r_d[6]; lb = r_d[7];
            end
            4'd4: begin
                lw = r_fw[1]; la = r_l[0]; lb = r_l[1];
            end
            4'd5: begin
                lw = r_fw[1]; la = r_l[2]; lb = r_l[3];
            end
            4'd7: begin
                lw = r_fw[2]; la = r_l[4]; lb = r_l[5];
            end
            default: begin
                lw = '0;
            end
        endcase
    end

    // Multiplier operand select
    always_comb begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
        case (r_state)
            ST_FADE: begin
                case (r_step)
                    4'd0: begin
                        mac_a = t_cur;
                        mac_b = t_cur;
                    end
                    4'd1: begin
                        mac_a = mac_y;
                        mac_b = (r_fade == FADE_CUBIC) ? (THREE_Q16 - (t_cur <<< 1)) : t_cur;
                    end
                    4'd2: begin
                        mac_a = t_cur;
                        mac_b = (t_cur <<< 2) + (t_cur <<< 1) - FIFTEEN_Q16;
                        mac_c = TEN_Q16;
                    end
                    4'd3: begin
                        mac_a = r_tmp;
                        mac_b = mac_y;
                    end
                    default: begin
                        mac_a = '0;
                    end
                endcase
            end
            ST_LERP: begin
                mac_a = lw;
                mac_b = lb - la;
                mac_c = la;
            end
            default: begin
                mac_a = '0;
            end
        endcase
    end

    gn3_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_y   (mac_y)
    );

    // Hash chain read address
    always_comb begin
        case (r_step)
            4'd0:    ram_raddr = hadd('0, r_cell[0], 1'b0);
            4'd1:    ram_raddr = hadd('0, r_cell[0], 1'b1);
            4'd2:    ram_raddr = hadd(r_h[0], r_cell[1], 1'b0);
            4'd3:    ram_raddr = hadd(r_h[0], r_cell[1], 1'b1);
            4'd4:    ram_raddr = hadd(r_h[1], r_cell[1], 1'b0);
            4'd5:    ram_raddr = hadd(r_h[1], r_cell[1], 1'b1);
            4'd6:    ram_raddr = hadd(r_h[2], r_cell[2], 1'b0);
            4'd7:    ram_raddr = hadd(r_h[4], r_cell[2], 1'b0);
            4'd8:    ram_raddr = hadd(r_h[3], r_cell[2], 1'b0);
            4'd9:    ram_raddr = hadd(r_h[5], r_cell[2], 1'b0);
            4'd10:   ram_raddr = hadd(r_h[2], r_cell[2], 1'b1);
            4'd11:   ram_raddr = hadd(r_h[4], r_cell[2], 1'b1);
            4'd12:   ram_raddr = hadd(r_h[3], r_cell[2], 1'b1);
            4'd13:   ram_raddr = hadd(r_h[5], r_cell[2], 1'b1);
            default: ram_raddr = '0;
        endcase
    end

    assign ram_we = in_acc && (i_in.operation == OP_LOAD);

    gn3_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IW'(i_in.table_index)),
        .i_wdata (i_in.table_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Corner dot product from the returning hash
    assign corner = 3'(r_step - 4'd7);
    assign grad   = grad_of(ram_rdata);
    assign dx     = corner[0] ? (t_q'({1'b0, r_frac[0]}) - ONE_Q16) : t_q'({1'b0, r_frac[0]});
    assign dy     = corner[1] ? (t_q'({1'b0, r_frac[1]}) - ONE_Q16) : t_q'({1'b0, r_frac[1]});
    assign dz     = corner[2] ? (t_q'({1'b0, r_frac[2]}) - ONE_Q16) : t_q'({1'b0, r_frac[2]});
    assign dot    = grad_term(grad.gx, dx) + grad_term(grad.gy, dy) + grad_term(grad.gz, dz);

    // Saturate the blended value to plus or minus one
    always_comb begin
        if (mac_y > ONE_Q16) begin
            n_noise = NOISE_W'(ONE_Q16);
        end else if (mac_y < -ONE_Q16) begin
            n_noise = NOISE_W'(-ONE_Q16);
        end else begin
            n_noise = mac_y[NOISE_W-1:0];
        end
    end

    // Sequencer, output register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_axis  <= '0;
            r_fade  <= FADE_QUINTIC;
            r_ov    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_fade <= t_fade'(cfg_val);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.operation == OP_SAMPLE)) begin
                        r_frac[0] <= i_in.coord_x[FRAC_W-1:0];
                        r_frac[1] <= i_in.coord_y[FRAC_W-1:0];
                        r_frac[2] <= i_in.coord_z[FRAC_W-1:0];
                        r_cell[0] <= i_in.coord_x[FRAC_W +: IW];
                        r_cell[1] <= i_in.coord_y[FRAC_W +: IW];
                        r_cell[2] <= i_in.coord_z[FRAC_W +: IW];
                        r_step    <= '0;
                        r_axis    <= '0;
                        r_state   <= ST_FADE;
                    end
                end
                ST_FADE: begin
                    if (r_step == 4'd2) begin
                        r_tmp <= mac_y;
                    end
                    if (r_step == fade_last) begin
                        r_fw[r_axis] <= (r_fade == FADE_LINEAR) ? t_cur : mac_y;
                        r_step <= '0;
                        if (r_axis == 2'd2) begin
                            r_axis  <= '0;
                            r_state <= ST_HASH;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_HASH: begin
                    if ((r_step >= 4'd1) && (r_step <= 4'd6)) begin
                        r_h[3'(r_step - 4'd1)] <= ram_rdata;
                    end
                    if (r_step >= 4'd7) begin
                        r_d[corner] <= dot;
                    end
                    if (r_step == 4'd14) begin
                        r_step  <= '0;
                        r_state <= ST_LERP;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_LERP: begin
                    if ((r_step >= 4'd1) && (r_step <= 4'd6)) begin
                        r_l[3'(r_step - 4'd1)] <= mac_y;
                    end
                    if (r_step == 4'd8) begin
                        r_res   <= n_noise;
                        r_step  <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_nv    <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A sample in flight blocks new beats
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_in.ready)
        else $error("input ready while a sample is in flight");

    // Output stays within plus or minus one
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.noise_value <= 18'sd65536) &&
                         (o_out.noise_value >= -18'sd65536)))
        else $error("noise value outside saturation range");

    // A load beat never starts the sequencer
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.operation == OP_LOAD)) |=> (r_state == ST_IDLE))
        else $error("load beat left the idle state");

    // A finished result waits while the output register is blocked
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_ov && !o_out.ready) |=> (r_state == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

[hw/rtl/gn3_ram.sv]
// ============================================================================
// gn3_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/gn3_mac.sv]
// ============================================================================
// gn3_mac: shared multiply, round and add unit
// Computes c + round_half_up(a * b / 65536) and registers the result.
// ============================================================================
module gn3_mac (
    input  logic         i_clk,
    input  gn3_pkg::t_q  i_a,
    input  gn3_pkg::t_q  i_b,
    input  gn3_pkg::t_q  i_c,
    output gn3_pkg::t_q  o_y
);
    import gn3_pkg::*;

    localparam int PW = 2 * QW;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    t_q                   r_y;

    // Round the Q.32 product back to Q.16 (floor after adding one half)
    assign prod = i_a * i_b;
    assign rnd  = (prod + PW'(32768)) >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        r_y <= i_c + rnd[QW-1:0];
    end

    assign o_y = r_y;
endmodule
